### rtl/core/rlrv_pkg.sv
// Shared constants, types and command codes of the rolling volatility block.
// No dependencies; compiled first.
package rlrv_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int RING_AW    = $clog2(MAX_WINDOW);
    localparam int PRICE_W    = 32;
    localparam int LEN_W      = 7;
    localparam int RET_W      = 32;
    localparam int SUM_W      = 40;
    localparam int SQ_W       = 64;
    localparam int LOG_W      = 33;
    localparam int ACC_W      = 82;
    localparam int NUM_W      = 80;
    localparam int DEN_W      = 12;
    localparam int CNT_W      = 5;
    localparam int OUT_W      = 32;
    localparam int LVL_W      = 2;

    localparam logic [LEN_W-1:0] LEN_RESET  = 7'd20;
    localparam logic [LEN_W-1:0] LEN_MIN    = 7'd2;
    localparam logic [LEN_W-1:0] LEN_MAX    = 7'(MAX_WINDOW);
    localparam logic [31:0]      LN2_Q30    = 32'd744261118;
    localparam logic [31:0]      ANNUAL_K   = 32'd1664562796;
    localparam logic [31:0]      CLAMP_LOG2 = 32'hC000_0000;
    localparam logic [31:0]      DAILY_K    = 32'd100;
    localparam logic [31:0]      LVL_LOW    = 32'(15 << 16);
    localparam logic [31:0]      LVL_MED    = 32'(25 << 16);
    localparam logic [31:0]      LVL_HIGH   = 32'(40 << 16);

    localparam logic [CNT_W-1:0] LOG_LAST  = 5'd27;
    localparam logic [CNT_W-1:0] DIV_LAST  = 5'd19;
    localparam logic [CNT_W-1:0] SQRT_LAST = 5'd31;

    localparam logic [LVL_W-1:0] LEVEL_LOW  = 2'd0;
    localparam logic [LVL_W-1:0] LEVEL_MED  = 2'd1;
    localparam logic [LVL_W-1:0] LEVEL_HIGH = 2'd2;
    localparam logic [LVL_W-1:0] LEVEL_VERY = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_LOGINIT, S_LOGITER, S_LOGDONE, S_LNMUL, S_LNRND,
        S_SQNEW, S_SQOLD, S_ACCUM, S_SETPREV, S_MAC0, S_MAC1, S_MAC2, S_MAC3,
        S_MAC4, S_MAC5, S_DIVINIT, S_DIV, S_SQRTINIT, S_SQRT, S_OUT1, S_OUT2,
        S_OUT3, S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        C_NOP, C_LOAD, C_CLEAR, C_LOGINIT, C_LOGITER, C_LNMUL, C_LNRND,
        C_SQNEW, C_SQOLD, C_ACCUM, C_SETPREV, C_MAC0, C_MAC1, C_MAC2, C_MAC3,
        C_MAC4, C_MAC5, C_DIVINIT, C_DIV, C_SQRTINIT, C_SQRT, C_OUT1, C_OUT2,
        C_OUT3, C_EMIT
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic cfg_take;
    } t_ctrl;

    typedef struct packed {
        logic cur_pos;
        logic have_prev;
        logic prev_pos;
        logic run_full;
        logic out_busy;
    } t_stat;

endpackage

### rtl/core/rlrv_if.sv
// Request channels of the rolling volatility block: price in, result out,
// window register write. Depends on rlrv_pkg.
interface rlrv_price_if;
    import rlrv_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [PRICE_W-1:0] close_price;
    modport source (output valid, output close_price, input ready);
    modport sink   (input valid, input close_price, output ready);
endinterface

interface rlrv_vol_if;
    import rlrv_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] daily_vol_percent;
    logic [OUT_W-1:0] annual_vol_percent;
    logic [LVL_W-1:0] vol_level;
    modport source (output valid, output daily_vol_percent, output annual_vol_percent,
                    output vol_level, input ready);
    modport sink   (input valid, input daily_vol_percent, input annual_vol_percent,
                    input vol_level, output ready);
endinterface

interface rlrv_cfg_if;
    import rlrv_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] window_length;
    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

### rtl/core/rolling_log_return_volatility.sv
// Top level of the rolling volatility block: sequencer plus datapath.
// Depends on rlrv_pkg, rlrv_if, rlrv_ctrl and rlrv_dp.
//
// Takes one closing price per request and, once the last window_length log
// returns are all valid, delivers the sample standard deviation of the window
// as a daily percentage and its annualized value, both unsigned Q16.16, and a
// level class. One price is worked at a time. A nonpositive price, a positive
// price that forms no return (first price, or one after a bad price), a price
// that forms a return but yields no result and a price that yields a result
// each take their own path through the sequencer; a price that yields a result
// also waits while the previous result still sits in the output register. The
// longest path runs through the 28-step log2 iteration on the shared 32x32
// multiplier, the variance divider (4 quotient bits a cycle) and the 32-step
// square root. The result sits in an output register, so the next price is
// taken while it waits. Window writes are taken only between prices and
// restart the window.
module rolling_log_return_volatility (
    input logic         i_clk,
    input logic         i_rst_n,
    rlrv_price_if.sink  i_price,
    rlrv_vol_if.source  o_vol,
    rlrv_cfg_if.sink    i_cfg
);
    import rlrv_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    // Sequencer
    rlrv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_price.valid),
        .i_cfg_valid (i_cfg.valid),
        .i_stat      (stat),
        .o_in_ready  (i_price.ready),
        .o_cfg_ready (i_cfg.ready),
        .o_ctrl      (ctrl)
    );

    // Datapath
    rlrv_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctrl               (ctrl),
        .i_close_price        (i_price.close_price),
        .i_window_length      (i_cfg.window_length),
        .i_out_ready          (o_vol.ready),
        .o_stat               (stat),
        .o_out_valid          (o_vol.valid),
        .o_daily_vol_percent  (o_vol.daily_vol_percent),
        .o_annual_vol_percent (o_vol.annual_vol_percent),
        .o_vol_level          (o_vol.vol_level)
    );

endmodule

### rtl/core/rlrv_ctrl.sv
// Sequencer of the rolling volatility block: steps the datapath through one
// price request. Depends on rlrv_pkg.
module rlrv_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_cfg_valid,
    input  rlrv_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output logic            o_cfg_ready,
    output rlrv_pkg::t_ctrl o_ctrl
);
    import rlrv_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    // Advance state and loop counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (!i_cfg_valid && i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_stat.cur_pos ? S_LOGINIT : S_SETPREV;
            end
            S_LOGINIT: begin
                n_state = S_LOGITER;
                n_cnt   = LOG_LAST;
            end
            S_LOGITER: begin
                if (r_cnt == '0) n_state = S_LOGDONE;
                else n_cnt = r_cnt - 1'b1;
            end
            S_LOGDONE: begin
                n_state = (i_stat.have_prev && i_stat.prev_pos) ? S_LNMUL : S_SETPREV;
            end
            S_LNMUL:   n_state = S_LNRND;
            S_LNRND:   n_state = S_SQNEW;
            S_SQNEW:   n_state = S_SQOLD;
            S_SQOLD:   n_state = S_ACCUM;
            S_ACCUM:   n_state = S_SETPREV;
            S_SETPREV: n_state = i_stat.run_full ? S_MAC0 : S_IDLE;
            S_MAC0:    n_state = S_MAC1;
            S_MAC1:    n_state = S_MAC2;
            S_MAC2:    n_state = S_MAC3;
            S_MAC3:    n_state = S_MAC4;
            S_MAC4:    n_state = S_MAC5;
            S_MAC5:    n_state = S_DIVINIT;
            S_DIVINIT: begin
                n_state = S_DIV;
                n_cnt   = DIV_LAST;
            end
            S_DIV: begin
                if (r_cnt == '0) n_state = S_SQRTINIT;
                else n_cnt = r_cnt - 1'b1;
            end
            S_SQRTINIT: begin
                n_state = S_SQRT;
                n_cnt   = SQRT_LAST;
            end
            S_SQRT: begin
                if (r_cnt == '0) n_state = S_OUT1;
                else n_cnt = r_cnt - 1'b1;
            end
            S_OUT1: n_state = S_OUT2;
            S_OUT2: n_state = S_OUT3;
            S_OUT3: n_state = S_EMIT;
            S_EMIT: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands and handshake
    always_comb begin
        o_ctrl.cmd      = C_NOP;
        o_ctrl.cfg_take = 1'b0;
        o_cfg_ready     = (r_state == S_IDLE);
        o_in_ready      = (r_state == S_IDLE) && !i_cfg_valid;
        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) o_ctrl.cfg_take = 1'b1;
                else if (i_in_valid) o_ctrl.cmd = C_LOAD;
            end
            S_CHECK: begin
                if (i_stat.cur_pos) o_ctrl.cmd = C_LOGINIT;
                else if (i_stat.have_prev) o_ctrl.cmd = C_CLEAR;
            end
            S_LOGINIT:  o_ctrl.cmd = C_LOGINIT;
            S_LOGITER:  o_ctrl.cmd = C_LOGITER;
            S_LOGDONE: begin
                if (i_stat.have_prev && !i_stat.prev_pos) o_ctrl.cmd = C_CLEAR;
            end
            S_LNMUL:    o_ctrl.cmd = C_LNMUL;
            S_LNRND:    o_ctrl.cmd = C_LNRND;
            S_SQNEW:    o_ctrl.cmd = C_SQNEW;
            S_SQOLD:    o_ctrl.cmd = C_SQOLD;
            S_ACCUM:    o_ctrl.cmd = C_ACCUM;
            S_SETPREV:  o_ctrl.cmd = C_SETPREV;
            S_MAC0:     o_ctrl.cmd = C_MAC0;
            S_MAC1:     o_ctrl.cmd = C_MAC1;
            S_MAC2:     o_ctrl.cmd = C_MAC2;
            S_MAC3:     o_ctrl.cmd = C_MAC3;
            S_MAC4:     o_ctrl.cmd = C_MAC4;
            S_MAC5:     o_ctrl.cmd = C_MAC5;
            S_DIVINIT:  o_ctrl.cmd = C_DIVINIT;
            S_DIV:      o_ctrl.cmd = C_DIV;
            S_SQRTINIT: o_ctrl.cmd = C_SQRTINIT;
            S_SQRT:     o_ctrl.cmd = C_SQRT;
            S_OUT1:     o_ctrl.cmd = C_OUT1;
            S_OUT2:     o_ctrl.cmd = C_OUT2;
            S_OUT3:     o_ctrl.cmd = C_OUT3;
            S_EMIT: begin
                if (!i_stat.out_busy) o_ctrl.cmd = C_EMIT;
            end
            default: o_ctrl.cmd = C_NOP;
        endcase
    end

endmodule

### rtl/core/rlrv_dp.sv
// Datapath of the rolling volatility block: log unit, return ring, running
// sums, variance divider, square root and output register. Depends on rlrv_pkg.
module rlrv_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rlrv_pkg::t_ctrl                    i_ctrl,
    input  logic signed [rlrv_pkg::PRICE_W-1:0] i_close_price,
    input  logic [rlrv_pkg::LEN_W-1:0]         i_window_length,
    input  logic                               i_out_ready,
    output rlrv_pkg::t_stat                    o_stat,
    output logic                               o_out_valid,
    output logic [rlrv_pkg::OUT_W-1:0]         o_daily_vol_percent,
    output logic [rlrv_pkg::OUT_W-1:0]         o_annual_vol_percent,
    output logic [rlrv_pkg::LVL_W-1:0]         o_vol_level
);
    import rlrv_pkg::*;

    // Price history and log unit
    logic [PRICE_W-1:0]  r_cur;
    logic                r_prev_pos, r_have_prev;
    logic [LOG_W-1:0]    r_prev_log;
    logic [4:0]          r_e;
    logic [27:0]         r_frac;
    logic [30:0]         r_m;
    // Window state
    logic [LEN_W-1:0]    r_len;
    logic [RING_AW-1:0]  r_ptr;
    logic [LEN_W-1:0]    r_cnt;
    logic [SUM_W-1:0]    r_sum;
    logic [SQ_W-1:0]     r_sq;
    logic [RET_W-1:0]    r_ring [MAX_WINDOW];
    logic [RET_W-1:0]    r_old, r_ret;
    logic                r_neg;
    // Statistics
    logic [63:0]         r_prod;
    logic [ACC_W-1:0]    r_acc;
    logic [NUM_W-1:0]    r_num;
    logic [DEN_W-1:0]    r_rem, r_den;
    logic [63:0]         r_x, r_res, r_bit;
    logic [OUT_W-1:0]    r_daily, r_annual;
    logic                r_ovalid;
    logic [OUT_W-1:0]    r_odaily, r_oannual;
    logic [LVL_W-1:0]    r_olevel;

    logic [4:0]          e_pos;
    logic                cur_pos, run_full;
    logic [LOG_W-1:0]    log_cur;
    logic [LOG_W:0]      diff, dmag;
    logic [31:0]         clamped;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         mul_p;
    logic [31:0]         sq_t;
    logic [63:0]         rnd;
    logic [33:0]         rmag;
    logic [31:0]         ret_mag, old_mag;
    logic [SUM_W-1:0]    smag;
    logic [LEN_W-1:0]    cfg_len;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_rem;
    logic [DEN_W:0]      div_t;
    logic [63:0]         sq_try;
    logic [63:0]         d_sum, a_sum;

    assign cur_pos  = (r_cur != '0) && !r_cur[PRICE_W-1];
    assign run_full = (r_cnt >= r_len);
    assign log_cur  = {r_e, r_frac};
    assign o_stat   = '{cur_pos: cur_pos, have_prev: r_have_prev, prev_pos: r_prev_pos,
                        run_full: run_full, out_busy: r_ovalid && !i_out_ready};

    // Find the leading one of the positive price
    always_comb begin
        e_pos = '0;
        for (int i = 0; i < PRICE_W - 1; i++) begin
            if (r_cur[i]) e_pos = 5'(i);
        end
    end

    // Clamp the log2 difference
    assign diff    = {1'b0, log_cur} - {1'b0, r_prev_log};
    assign dmag    = diff[LOG_W] ? (~diff + 1'b1) : diff;
    assign clamped = (dmag > {2'b0, CLAMP_LOG2}) ? CLAMP_LOG2 : dmag[31:0];

    assign ret_mag = r_ret[31] ? (~r_ret + 1'b1) : r_ret;
    assign old_mag = r_old[31] ? (~r_old + 1'b1) : r_old;
    assign smag    = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
    assign cfg_len = (i_window_length < LEN_MIN) ? LEN_MIN :
                     (i_window_length > LEN_MAX) ? LEN_MAX : i_window_length;

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_ctrl.cmd)
            C_LOGITER: begin mul_a = {1'b0, r_m}; mul_b = {1'b0, r_m}; end
            C_LNMUL:   begin mul_a = clamped; mul_b = LN2_Q30; end
            C_SQNEW:   begin mul_a = ret_mag; mul_b = ret_mag; end
            C_SQOLD:   begin mul_a = old_mag; mul_b = old_mag; end
            C_MAC0:    begin mul_a = 32'(r_len) << 10; mul_b = r_sq[31:0]; end
            C_MAC1:    begin mul_a = 32'(r_len) << 10; mul_b = r_sq[63:32]; end
            C_MAC2:    begin mul_a = smag[31:0]; mul_b = smag[31:0]; end
            C_MAC3:    begin mul_a = smag[31:0]; mul_b = 32'(smag[SUM_W-1:32]); end
            C_MAC4:    begin mul_a = 32'(smag[SUM_W-1:32]); mul_b = 32'(smag[SUM_W-1:32]); end
            C_OUT1:    begin mul_a = r_res[31:0]; mul_b = DAILY_K; end
            C_OUT2:    begin mul_a = r_res[31:0]; mul_b = ANNUAL_K; end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;
    assign sq_t  = mul_p[61:30];

    // Round and saturate the log return
    assign rnd  = r_prod + 64'(1 << 29);
    assign rmag = rnd[63:30];

    // Four restoring divide steps per cycle
    always_comb begin
        div_num = r_num;
        div_rem = r_rem;
        div_t   = '0;
        for (int k = 0; k < 4; k++) begin
            div_t = {div_rem, div_num[NUM_W-1]};
            if (div_t >= {1'b0, r_den}) begin
                div_rem = DEN_W'(div_t - {1'b0, r_den});
                div_num = {div_num[NUM_W-2:0], 1'b1};
            end else begin
                div_rem = div_t[DEN_W-1:0];
                div_num = {div_num[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign sq_try = r_res + r_bit;
    assign d_sum  = r_prod + 64'd2048;
    assign a_sum  = r_prod + 64'h8000_0000;

    // Return ring: write new return, read the one that leaves the window
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmd == C_SQNEW) r_ring[r_ptr] <= r_ret;
        if (i_ctrl.cmd == C_LNMUL) r_old <= r_ring[r_ptr - r_len[RING_AW-1:0]];
    end

    // Control state: history flags, window, run count and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_pos  <= 1'b0;
            r_len       <= LEN_RESET;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_ctrl.cfg_take) begin
                r_len <= cfg_len;
                r_cnt <= '0;
                r_sum <= '0;
                r_sq  <= '0;
            end
            case (i_ctrl.cmd)
                C_CLEAR: begin
                    r_cnt <= '0;
                    r_sum <= '0;
                    r_sq  <= '0;
                end
                C_SQNEW: begin
                    r_ptr <= r_ptr + 1'b1;
                    r_sum <= r_sum + {{(SUM_W-RET_W){r_ret[31]}}, r_ret}
                           - (run_full ? {{(SUM_W-RET_W){r_old[31]}}, r_old} : '0);
                end
                C_SQOLD: r_sq <= r_sq + (r_prod >> 10);
                C_ACCUM: begin
                    if (run_full) r_sq <= r_sq - (r_prod >> 10);
                    if (r_cnt != LEN_MAX) r_cnt <= r_cnt + 1'b1;
                end
                C_SETPREV: begin
                    r_have_prev <= 1'b1;
                    r_prev_pos  <= cur_pos;
                end
                default: ;
            endcase
            // Hold result until taken
            if (i_ctrl.cmd == C_EMIT) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (i_ctrl.cmd)
            C_LOAD: r_cur <= i_close_price;
            C_LOGINIT: begin
                r_e    <= e_pos;
                r_m    <= r_cur[30:0] << (5'd30 - e_pos);
                r_frac <= '0;
            end
            C_LOGITER: begin
                if (sq_t[31]) begin
                    r_m    <= sq_t[31:1];
                    r_frac <= {r_frac[26:0], 1'b1};
                end else begin
                    r_m    <= sq_t[30:0];
                    r_frac <= {r_frac[26:0], 1'b0};
                end
            end
            C_LNMUL: r_neg <= diff[LOG_W];
            C_LNRND: begin
                if (r_neg) r_ret <= (rmag > 34'h0_8000_0000) ? 32'h8000_0000 : -rmag[31:0];
                else r_ret <= (rmag > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : rmag[31:0];
            end
            C_SETPREV: begin
                r_prev_log <= log_cur;
            end
            C_MAC0: r_acc <= '0;
            C_MAC1: r_acc <= r_acc + {18'b0, r_prod};
            C_MAC2: r_acc <= r_acc + ({18'b0, r_prod} << 32);
            C_MAC3: r_acc <= r_acc - {18'b0, r_prod};
            C_MAC4: r_acc <= r_acc - ({18'b0, r_prod} << 33);
            C_MAC5: r_acc <= r_acc - ({18'b0, r_prod} << 64);
            C_DIVINIT: begin
                r_num <= r_acc[ACC_W-1] ? '0 : r_acc[NUM_W-1:0];
                r_rem <= '0;
                r_den <= DEN_W'(r_len) * (DEN_W'(r_len) - 1'b1);
            end
            C_DIV: begin
                r_num <= div_num;
                r_rem <= div_rem;
            end
            C_SQRTINIT: begin
                r_x   <= (r_num[NUM_W-1:64] != '0) ? '1 : r_num[63:0];
                r_res <= '0;
                r_bit <= 64'(1) << 62;
            end
            C_SQRT: begin
                if (r_x >= sq_try) begin
                    r_x   <= r_x - sq_try;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            C_OUT2: r_daily  <= d_sum[43:12];
            C_OUT3: r_annual <= a_sum[63:32];
            C_EMIT: begin
                r_odaily  <= r_daily;
                r_oannual <= r_annual;
                if (r_annual < LVL_LOW) r_olevel <= LEVEL_LOW;
                else if (r_annual < LVL_MED) r_olevel <= LEVEL_MED;
                else if (r_annual < LVL_HIGH) r_olevel <= LEVEL_HIGH;
                else r_olevel <= LEVEL_VERY;
            end
            default: ;
        endcase
    end

    assign o_out_valid          = r_ovalid;
    assign o_daily_vol_percent  = r_odaily;
    assign o_annual_vol_percent = r_oannual;
    assign o_vol_level          = r_olevel;

endmodule
